/* hw/rtl/bibp_pkg.sv */
// Package for the boot image block parser.
// Holds the phase and result kind codes, the result record type and the sector layout helpers.
// No dependencies.
package bibp_pkg;

    localparam int NUM_SECTORS_DEF    = 14;
    localparam int RESERVED_WORDS_DEF = 8;

    localparam int GROUP_WORDS = 8;
    localparam int GIDX_W      = 3;
    localparam int WC_W        = 4;
    localparam int BOUND_W     = 33;
    localparam int PADDR_W     = 4;
    localparam int FIFO_DEPTH  = 4;
    localparam int FPTR_W      = 2;
    localparam int FCNT_W      = 3;

    localparam logic [15:0] KEY_VALUE  = 16'h08AA;
    localparam logic [15:0] BLANK_WORD = 16'hFFFF;
    localparam logic [31:0] ADDR_STEP  = 32'h0000_0008;

    localparam logic [31:0] FLASH_BASE_RST  = 32'd524288;
    localparam logic [16:0] SMALL_WORDS_RST = 17'd8192;
    localparam logic [20:0] LARGE_WORDS_RST = 21'd32768;

    localparam logic [1:0] REG_FLASH_BASE  = 2'd0;
    localparam logic [1:0] REG_SMALL_WORDS = 2'd1;
    localparam logic [1:0] REG_LARGE_WORDS = 2'd2;

    typedef enum logic [2:0] {
        PH_KEY      = 3'd0,
        PH_RESERVED = 3'd1,
        PH_ENTRY    = 3'd2,
        PH_SIZE     = 3'd3,
        PH_DEST     = 3'd4,
        PH_DATA     = 3'd5,
        PH_DONE     = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        KIND_ERASE       = 3'd0,
        KIND_PROGRAM     = 3'd1,
        KIND_ENTRY_GROUP = 3'd2,
        KIND_DONE_OK     = 3'd3,
        KIND_DONE_BAD    = 3'd4
    } kind_t;

    typedef logic [GROUP_WORDS-1:0][15:0] group_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [3:0]  sector;
        group_t      data;
        logic        last;
    } res_t;

    // Sectors 4 to 9 are large, all others small.
    function automatic int small_before(input int idx);
        int cnt;
        cnt = 0;
        for (int j = 0; j < idx; j++) begin
            if (j < 4 || j > 9) begin
                cnt++;
            end
        end
        return cnt;
    endfunction

endpackage

/* hw/rtl/boot_image_block_parser.sv */
// Boot image block parser: top level with parser state, sector lookup and result queue.
// Depends on bibp_pkg.
//
//   channel  | ports                               | direction
//   input    | s_valid s_ready s_word s_restart    | in
//   result   | m_valid m_ready m_kind m_address    | out
//            | m_sector m_data0..m_data7 m_last    |
//   config   | psel penable pwrite paddr pwdata    | in, prdata pready out
//
// One image word is taken per cycle while s_ready is high; its results are written
// into a four-entry result queue in the same cycle and leave at one per cycle while
// m_ready is high. s_ready is high while the queue has room for two results, so both
// results of a word fit.
// Sector start addresses are recomputed on each configuration write.
// Reset is synchronous on aresetn and empties the queue; no clearing pass.
module boot_image_block_parser #(
    parameter int NUM_SECTORS    = bibp_pkg::NUM_SECTORS_DEF,
    parameter int RESERVED_WORDS = bibp_pkg::RESERVED_WORDS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [15:0]                  s_word,
    input  logic                         s_restart,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_kind,
    output logic [31:0]                  m_address,
    output logic [3:0]                   m_sector,
    output logic [15:0]                  m_data0,
    output logic [15:0]                  m_data1,
    output logic [15:0]                  m_data2,
    output logic [15:0]                  m_data3,
    output logic [15:0]                  m_data4,
    output logic [15:0]                  m_data5,
    output logic [15:0]                  m_data6,
    output logic [15:0]                  m_data7,
    output logic                         m_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bibp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import bibp_pkg::*;

    localparam int SEC_W = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;

    logic [31:0] flash_base_reg, flash_base_next;
    logic [16:0] small_words_reg, small_words_next;
    logic [20:0] large_words_reg, large_words_next;
    logic [BOUND_W-1:0] bound_reg [NUM_SECTORS+1];
    logic [BOUND_W-1:0] bound_next [NUM_SECTORS+1];
    logic [31:0] fb_src;
    logic [16:0] sm_src;
    logic [20:0] lg_src;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    phase_t            phase_reg, phase_next, phase_eff;
    logic [WC_W-1:0]   wc_reg, wc_next, wc_eff;
    logic [31:0]       entry_addr_reg, entry_addr_next, entry_addr_eff;
    logic [31:0]       dest_reg, dest_next, dest_eff;
    logic [15:0]       left_reg, left_next, left_eff, left_dec;
    group_t            group_reg;
    group_t            entry_store_reg, entry_store_next, entry_store_eff;
    logic [NUM_SECTORS-1:0] erased_reg, erased_next, erased_eff;
    logic              key_bad_reg, key_bad_next, key_bad_eff;

    logic              s_accept;
    logic [WC_W:0]     wc_inc;
    logic [GIDX_W-1:0] gidx;
    logic              group_fin;
    group_t            group_full;
    logic              is_entry;
    logic              blank;
    logic [NUM_SECTORS-1:0] in_sec;
    logic              sec_hit;
    logic [SEC_W-1:0]  sec_idx;
    logic              do_erase;

    res_t        res0, res1;
    logic [1:0]  n_res;

    res_t              fifo_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FCNT_W-1:0] cnt_reg;
    logic              m_pop;
    res_t              head;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        flash_base_next  = flash_base_reg;
        small_words_next = small_words_reg;
        large_words_next = large_words_reg;
        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FLASH_BASE:  flash_base_next  = pwdata;
                REG_SMALL_WORDS: small_words_next = pwdata[16:0];
                REG_LARGE_WORDS: large_words_next = pwdata[20:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FLASH_BASE:  prdata = flash_base_reg;
            REG_SMALL_WORDS: prdata = {15'd0, small_words_reg};
            REG_LARGE_WORDS: prdata = {11'd0, large_words_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign fb_src = aresetn ? flash_base_next  : FLASH_BASE_RST;
    assign sm_src = aresetn ? small_words_next : SMALL_WORDS_RST;
    assign lg_src = aresetn ? large_words_next : LARGE_WORDS_RST;

    for (genvar i = 0; i <= NUM_SECTORS; i++) begin : g_bound
        localparam int NS = small_before(i);
        localparam int NL = i - NS;
        assign bound_next[i] = BOUND_W'(fb_src)
                             + BOUND_W'(NS) * BOUND_W'(sm_src)
                             + BOUND_W'(NL) * BOUND_W'(lg_src);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_base_reg  <= FLASH_BASE_RST;
            small_words_reg <= SMALL_WORDS_RST;
            large_words_reg <= LARGE_WORDS_RST;
        end else begin
            flash_base_reg  <= flash_base_next;
            small_words_reg <= small_words_next;
            large_words_reg <= large_words_next;
        end
        if (!aresetn || cfg_wr) begin
            bound_reg <= bound_next;
        end
    end

    assign s_ready  = (cnt_reg <= FCNT_W'(FIFO_DEPTH - 2));
    assign s_accept = s_valid && s_ready;

    always_comb begin
        if (s_restart) begin
            phase_eff       = PH_KEY;
            wc_eff          = '0;
            entry_addr_eff  = '0;
            dest_eff        = '0;
            left_eff        = '0;
            entry_store_eff = '0;
            erased_eff      = '0;
            key_bad_eff     = 1'b0;
        end else begin
            phase_eff       = phase_reg;
            wc_eff          = wc_reg;
            entry_addr_eff  = entry_addr_reg;
            dest_eff        = dest_reg;
            left_eff        = left_reg;
            entry_store_eff = entry_store_reg;
            erased_eff      = erased_reg;
            key_bad_eff     = key_bad_reg;
        end
    end

    assign wc_inc    = {1'b0, wc_eff} + 1'b1;
    assign gidx      = wc_eff[GIDX_W-1:0];
    assign left_dec  = (left_eff != 16'd0) ? left_eff - 16'd1 : 16'd0;
    assign group_fin = (phase_eff == PH_DATA)
                    && ((wc_inc >= (WC_W+1)'(GROUP_WORDS)) || (left_dec == 16'd0));
    assign is_entry  = (dest_eff == entry_addr_eff);

    always_comb begin
        for (int j = 0; j < GROUP_WORDS; j++) begin
            if (GIDX_W'(j) < gidx) begin
                group_full[j] = group_reg[j];
            end else if (GIDX_W'(j) == gidx) begin
                group_full[j] = s_word;
            end else begin
                group_full[j] = BLANK_WORD;
            end
        end
    end

    always_comb begin
        blank = 1'b1;
        for (int j = 0; j < GROUP_WORDS; j++) begin
            if (group_full[j] != BLANK_WORD) begin
                blank = 1'b0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_SECTORS; i++) begin
            in_sec[i] = ({1'b0, dest_eff} >= bound_reg[i])
                     && ({1'b0, dest_eff} < bound_reg[i+1]);
        end
    end

    always_comb begin
        sec_hit = 1'b0;
        sec_idx = '0;
        for (int i = 0; i < NUM_SECTORS; i++) begin
            if (!sec_hit && in_sec[i]) begin
                sec_hit = 1'b1;
                sec_idx = SEC_W'(i);
            end
        end
    end

    assign do_erase = group_fin && !is_entry && !blank && sec_hit && !erased_eff[sec_idx];

    // Next state of the parser.
    always_comb begin
        phase_next       = phase_eff;
        wc_next          = wc_eff;
        entry_addr_next  = entry_addr_eff;
        dest_next        = dest_eff;
        left_next        = left_eff;
        entry_store_next = entry_store_eff;
        erased_next      = erased_eff;
        key_bad_next     = key_bad_eff;
        unique case (phase_eff)
            PH_KEY: begin
                key_bad_next = (s_word != KEY_VALUE);
                wc_next      = '0;
                phase_next   = (RESERVED_WORDS == 0) ? PH_ENTRY : PH_RESERVED;
            end
            PH_RESERVED: begin
                if (wc_inc >= (WC_W+1)'(RESERVED_WORDS)) begin
                    wc_next    = '0;
                    phase_next = PH_ENTRY;
                end else begin
                    wc_next = wc_inc[WC_W-1:0];
                end
            end
            PH_ENTRY: begin
                if (wc_eff == '0) begin
                    entry_addr_next = {s_word, 16'd0};
                    wc_next         = WC_W'(1);
                end else begin
                    entry_addr_next = {entry_addr_eff[31:16], s_word};
                    wc_next         = '0;
                    phase_next      = PH_SIZE;
                end
            end
            PH_SIZE: begin
                if (s_word == 16'd0) begin
                    phase_next = PH_DONE;
                end else begin
                    left_next  = s_word;
                    wc_next    = '0;
                    phase_next = PH_DEST;
                end
            end
            PH_DEST: begin
                if (wc_eff == '0) begin
                    dest_next = {s_word, 16'd0};
                    wc_next   = WC_W'(1);
                end else begin
                    dest_next  = {dest_eff[31:16], s_word};
                    wc_next    = '0;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                left_next = left_dec;
                if (group_fin) begin
                    wc_next = '0;
                    if (is_entry) begin
                        entry_store_next = group_full;
                        phase_next       = PH_SIZE;
                    end else begin
                        if (do_erase) begin
                            erased_next[sec_idx] = 1'b1;
                        end
                        dest_next  = dest_eff + ADDR_STEP;
                        phase_next = (left_dec == 16'd0) ? PH_SIZE : PH_DATA;
                    end
                end else begin
                    wc_next = wc_inc[WC_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // Results of the current word.
    always_comb begin
        res0  = '0;
        res1  = '0;
        n_res = 2'd0;
        unique case (phase_eff)
            PH_SIZE: begin
                if (s_word == 16'd0) begin
                    res0.kind    = KIND_ENTRY_GROUP;
                    res0.address = entry_addr_eff;
                    res0.data    = entry_store_eff;
                    res1.kind    = key_bad_eff ? KIND_DONE_BAD : KIND_DONE_OK;
                    res1.address = entry_addr_eff;
                    res1.last    = 1'b1;
                    n_res        = 2'd2;
                end
            end
            PH_DATA: begin
                if (group_fin && !is_entry && !blank) begin
                    if (do_erase) begin
                        res0.kind    = KIND_ERASE;
                        res0.address = bound_reg[sec_idx][31:0];
                        res0.sector  = 4'(sec_idx);
                        res1.kind    = KIND_PROGRAM;
                        res1.address = dest_eff;
                        res1.data    = group_full;
                        res1.last    = 1'b1;
                        n_res        = 2'd2;
                    end else begin
                        res0.kind    = KIND_PROGRAM;
                        res0.address = dest_eff;
                        res0.data    = group_full;
                        res0.last    = 1'b1;
                        n_res        = 2'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_KEY;
            wc_reg          <= '0;
            entry_addr_reg  <= '0;
            dest_reg        <= '0;
            left_reg        <= '0;
            entry_store_reg <= '0;
            erased_reg      <= '0;
            key_bad_reg     <= 1'b0;
        end else if (s_accept) begin
            phase_reg       <= phase_next;
            wc_reg          <= wc_next;
            entry_addr_reg  <= entry_addr_next;
            dest_reg        <= dest_next;
            left_reg        <= left_next;
            entry_store_reg <= entry_store_next;
            erased_reg      <= erased_next;
            key_bad_reg     <= key_bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && phase_eff == PH_DATA) begin
            group_reg[gidx] <= s_word;
        end
    end

    assign m_pop = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (s_accept && n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (s_accept && n_res == 2'd2) begin
            fifo_reg[wr_ptr_reg + FPTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (s_accept) begin
                wr_ptr_reg <= wr_ptr_reg + FPTR_W'(n_res);
            end
            if (m_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FPTR_W'(1);
            end
            cnt_reg <= cnt_reg + (s_accept ? FCNT_W'(n_res) : FCNT_W'(0))
                     - (m_pop ? FCNT_W'(1) : FCNT_W'(0));
        end
    end

    assign head      = fifo_reg[rd_ptr_reg];
    assign m_valid   = (cnt_reg != '0);
    assign m_kind    = head.kind;
    assign m_address = head.address;
    assign m_sector  = head.sector;
    assign m_data0   = head.data[0];
    assign m_data1   = head.data[1];
    assign m_data2   = head.data[2];
    assign m_data3   = head.data[3];
    assign m_data4   = head.data[4];
    assign m_data5   = head.data[5];
    assign m_data6   = head.data[6];
    assign m_data7   = head.data[7];
    assign m_last    = head.last;

endmodule

/* hw/rtl/bibp_checker.sv */
// Port-level checks for the boot image block parser, attached by bind.
// Depends on bibp_pkg and boot_image_block_parser.
module bibp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_kind,
    input logic       m_last
);
    import bibp_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_last))
        else $error("stalled result transaction changed");

    a_erase_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ERASE |-> !m_last)
        else $error("erase result marked last");

    a_erase_then_program: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_kind == KIND_ERASE |=> m_valid && m_kind == KIND_PROGRAM)
        else $error("erase not followed by program");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_DONE_OK || m_kind == KIND_DONE_BAD) |-> m_last)
        else $error("done result not marked last");

endmodule

bind boot_image_block_parser bibp_checker u_bibp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_kind  (m_kind),
    .m_last  (m_last)
);

/* bench/bibp_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the boot image block parser: watches the word, result and register ports,
// keeps its own model of the parser and compares every result transaction field by field.
// Depends on bibp_pkg.
module bibp_result_checker #(
    parameter int NUM_SECTORS    = bibp_pkg::NUM_SECTORS_DEF,
    parameter int RESERVED_WORDS = bibp_pkg::RESERVED_WORDS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [15:0]                  s_word,
    input  logic                         s_restart,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [2:0]                   m_kind,
    input  logic [31:0]                  m_address,
    input  logic [3:0]                   m_sector,
    input  logic [15:0]                  m_data0,
    input  logic [15:0]                  m_data1,
    input  logic [15:0]                  m_data2,
    input  logic [15:0]                  m_data3,
    input  logic [15:0]                  m_data4,
    input  logic [15:0]                  m_data5,
    input  logic [15:0]                  m_data6,
    input  logic [15:0]                  m_data7,
    input  logic                         m_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [bibp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output int                           fail_count,
    output int                           pending,
    output int                           result_count
);
    import bibp_pkg::*;

    logic [31:0]            base_cfg;
    logic [16:0]            small_cfg;
    logic [20:0]            large_cfg;

    phase_t                 ph;
    logic [3:0]             wcnt;
    logic [31:0]            entry_addr;
    logic [31:0]            dest_addr;
    logic [15:0]            left;
    group_t                 grp;
    group_t                 entry_grp;
    logic [NUM_SECTORS-1:0] erased;
    logic                   key_bad;

    res_t                   expected_results [$];
    int                     n_fail;
    int                     n_seen;

    function automatic res_t make_res(input kind_t k, input logic [31:0] a,
                                      input logic [3:0] s, input group_t d);
        res_t r;
        r.kind    = k;
        r.address = a;
        r.sector  = s;
        r.data    = d;
        r.last    = 1'b0;
        return r;
    endfunction

    task automatic clear_parser();
        ph         = PH_KEY;
        wcnt       = '0;
        entry_addr = '0;
        dest_addr  = '0;
        left       = '0;
        entry_grp  = '0;
        erased     = '0;
        key_bad    = 1'b0;
    endtask

    task automatic parse_word(input logic [15:0] w, input logic rs);
        res_t        outv [0:1];
        int          n;
        int          j;
        int          sec;
        logic [33:0] start;
        logic [33:0] size;
        logic [31:0] sec_start;
        n         = 0;
        sec       = -1;
        sec_start = '0;
        if (rs) begin
            clear_parser();
        end
        case (ph)
            PH_KEY: begin
                key_bad = (w != KEY_VALUE);
                wcnt    = '0;
                ph      = (RESERVED_WORDS == 0) ? PH_ENTRY : PH_RESERVED;
            end
            PH_RESERVED: begin
                wcnt++;
                if (int'(wcnt) >= RESERVED_WORDS) begin
                    wcnt = '0;
                    ph   = PH_ENTRY;
                end
            end
            PH_ENTRY: begin
                if (wcnt == 0) begin
                    entry_addr = {w, 16'h0000};
                    wcnt       = 4'd1;
                end else begin
                    entry_addr[15:0] = w;
                    wcnt             = '0;
                    ph               = PH_SIZE;
                end
            end
            PH_SIZE: begin
                if (w == 16'h0000) begin
                    outv[0] = make_res(KIND_ENTRY_GROUP, entry_addr, 4'd0, entry_grp);
                    outv[1] = make_res(key_bad ? KIND_DONE_BAD : KIND_DONE_OK, entry_addr,
                                       4'd0, '0);
                    n       = 2;
                    ph      = PH_DONE;
                end else begin
                    left = w;
                    wcnt = '0;
                    ph   = PH_DEST;
                end
            end
            PH_DEST: begin
                if (wcnt == 0) begin
                    dest_addr = {w, 16'h0000};
                    wcnt      = 4'd1;
                end else begin
                    dest_addr[15:0] = w;
                    wcnt            = '0;
                    ph              = PH_DATA;
                end
            end
            PH_DATA: begin
                grp[wcnt[2:0]] = w;
                wcnt++;
                if (left != 0) begin
                    left--;
                end
                if (int'(wcnt) >= GROUP_WORDS || left == 0) begin
                    for (j = int'(wcnt); j < GROUP_WORDS; j++) begin
                        grp[j] = BLANK_WORD;
                    end
                    wcnt = '0;
                    if (dest_addr == entry_addr) begin
                        entry_grp = grp;
                        ph        = PH_SIZE;
                    end else begin
                        if (grp != {GROUP_WORDS{BLANK_WORD}}) begin
                            start = {2'b00, base_cfg};
                            for (j = 0; j < NUM_SECTORS; j++) begin
                                size = (j >= 4 && j <= 9) ? 34'(large_cfg) : 34'(small_cfg);
                                if (sec < 0 && {2'b00, dest_addr} >= start &&
                                    {2'b00, dest_addr} < start + size) begin
                                    sec       = j;
                                    sec_start = start[31:0];
                                end
                                start = start + size;
                            end
                            if (sec >= 0 && !erased[sec]) begin
                                erased[sec] = 1'b1;
                                outv[n]     = make_res(KIND_ERASE, sec_start, 4'(sec), '0);
                                n++;
                            end
                            outv[n] = make_res(KIND_PROGRAM, dest_addr, 4'd0, grp);
                            n++;
                        end
                        dest_addr = dest_addr + ADDR_STEP;
                        ph        = (left == 0) ? PH_SIZE : PH_DATA;
                    end
                end
            end
            default: begin
            end
        endcase
        for (j = 0; j < n; j++) begin
            outv[j].last = (j == n - 1);
            expected_results.push_back(outv[j]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge aclk) begin
        res_t r;
        if (!aresetn) begin
            base_cfg  = FLASH_BASE_RST;
            small_cfg = SMALL_WORDS_RST;
            large_cfg = LARGE_WORDS_RST;
            grp       = '0;
            clear_parser();
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_FLASH_BASE:  base_cfg  = pwdata;
                    REG_SMALL_WORDS: small_cfg = pwdata[16:0];
                    REG_LARGE_WORDS: large_cfg = pwdata[20:0];
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                parse_word(s_word, s_restart);
            end
            if (m_valid && m_ready) begin
                n_seen++;
                if (expected_results.size() == 0) begin
                    $error("result transaction with none expected: kind %0d address 0x%0h",
                           m_kind, m_address);
                    n_fail++;
                end else begin
                    r = expected_results.pop_front();
                    check_field("kind", 32'(r.kind), 32'(m_kind));
                    check_field("address", r.address, m_address);
                    check_field("sector", 32'(r.sector), 32'(m_sector));
                    check_field("data0", 32'(r.data[0]), 32'(m_data0));
                    check_field("data1", 32'(r.data[1]), 32'(m_data1));
                    check_field("data2", 32'(r.data[2]), 32'(m_data2));
                    check_field("data3", 32'(r.data[3]), 32'(m_data3));
                    check_field("data4", 32'(r.data[4]), 32'(m_data4));
                    check_field("data5", 32'(r.data[5]), 32'(m_data5));
                    check_field("data6", 32'(r.data[6]), 32'(m_data6));
                    check_field("data7", 32'(r.data[7]), 32'(m_data7));
                    check_field("last", 32'(r.last), 32'(m_last));
                end
            end
        end
        fail_count   <= n_fail;
        pending      <= expected_results.size();
        result_count <= n_seen;
    end

endmodule

/* bench/boot_image_block_parser_test.sv */
`timescale 1ns / 100ps
// Top of the boot image block parser bench: clock, reset, register setup, image stimulus
// and the verdict. Depends on bibp_pkg, boot_image_block_parser and bibp_result_checker.
module boot_image_block_parser_test;
    import bibp_pkg::*;

    localparam int ITEMS       = 1400;
    localparam int LIMIT       = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;
    localparam int DRAIN       = 20;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic [15:0]         s_word    = '0;
    logic                s_restart = 1'b0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [2:0]          m_kind;
    logic [31:0]         m_address;
    logic [3:0]          m_sector;
    logic [15:0]         m_data0, m_data1, m_data2, m_data3;
    logic [15:0]         m_data4, m_data5, m_data6, m_data7;
    logic                m_last;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    int                  result_count;

    int                  cycle_count = 0;
    int                  n_items     = 0;
    int                  n_settings  = 1;
    int                  read_fails  = 0;
    int                  budget      = -1;
    int                  hold_count  = 0;
    logic                parked      = 1'b0;
    logic                quiet       = 1'b0;
    logic [31:0]         cfg_base    = FLASH_BASE_RST;
    int                  cfg_small   = int'(SMALL_WORDS_RST);
    int                  cfg_large   = int'(LARGE_WORDS_RST);

    boot_image_block_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .s_restart(s_restart),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_kind   (m_kind),
        .m_address(m_address),
        .m_sector (m_sector),
        .m_data0  (m_data0),
        .m_data1  (m_data1),
        .m_data2  (m_data2),
        .m_data3  (m_data3),
        .m_data4  (m_data4),
        .m_data5  (m_data5),
        .m_data6  (m_data6),
        .m_data7  (m_data7),
        .m_last   (m_last),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bibp_result_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_address   (m_address),
        .m_sector    (m_sector),
        .m_data0     (m_data0),
        .m_data1     (m_data1),
        .m_data2     (m_data2),
        .m_data3     (m_data3),
        .m_data4     (m_data4),
        .m_data5     (m_data5),
        .m_data6     (m_data6),
        .m_data7     (m_data7),
        .m_last      (m_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .pending     (pending),
        .result_count(result_count)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $error("run exceeded %0d cycles", LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_dest();
        int r;
        int span;
        r    = $urandom_range(0, 99);
        span = 8 * cfg_small + 6 * cfg_large;
        if (span < 8) span = 8;
        if (r < 60) return cfg_base + ($urandom_range(0, span - 1) & ~32'd7);
        if (r < 70) return cfg_base + $urandom_range(0, span - 1);
        if (r < 80) return $urandom;
        if (r < 88) return 32'hFFFF_FFF8 - 8 * $urandom_range(0, 3);
        return cfg_base - 8 * $urandom_range(1, 4);
    endfunction

    initial begin : result_sink
        int gap;
        int served;
        served = 0;
        forever begin
            @(posedge aclk);
            if (served < hold_count) begin
                served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (gap - 1) @(posedge aclk);
                end
            end
        end
    end

    task automatic send_word(input logic [15:0] w, input logic rs);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_word    <= w;
        s_restart <= rs;
        do @(posedge aclk); while (!s_ready);
        if (rs) parked = 1'b0;
        if (!parked) n_items++;
    endtask

    task automatic emit(input logic [15:0] w, input logic rs);
        if (budget == 0) return;
        if (budget > 0) budget--;
        send_word(w, rs);
    endtask

    task automatic apb_rw(input logic wr, input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wr ? val : 32'h0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (!wr && prdata !== val) begin
            $error("register %0d: expected 0x%0h, got 0x%0h", idx, val, prdata);
            read_fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_regs();
        apb_rw(1'b0, REG_FLASH_BASE, cfg_base);
        apb_rw(1'b0, REG_SMALL_WORDS, 32'(cfg_small));
        apb_rw(1'b0, REG_LARGE_WORDS, 32'(cfg_large));
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_config(input logic [31:0] base, input int small_w, input int large_w);
        quiesce();
        apb_rw(1'b1, REG_FLASH_BASE, base);
        apb_rw(1'b1, REG_SMALL_WORDS, 32'(small_w));
        apb_rw(1'b1, REG_LARGE_WORDS, 32'(large_w));
        cfg_base  = base;
        cfg_small = small_w;
        cfg_large = large_w;
        check_regs();
        n_settings++;
    endtask

    task automatic send_image();
        logic [31:0] dests [0:5];
        int          sizes [0:5];
        int          nblk;
        int          b;
        int          g;
        int          k;
        int          r;
        int          glen;
        logic [31:0] entry;
        logic        blank_grp;
        nblk   = $urandom_range(1, 5);
        for (b = 0; b < nblk; b++) begin
            r = $urandom_range(0, 99);
            if (r < 70) sizes[b] = $urandom_range(1, 24);
            else if (r < 90) sizes[b] = $urandom_range(25, 64);
            else sizes[b] = $urandom_range(1, 8);
            dests[b] = pick_dest();
        end
        r = $urandom_range(0, 99);
        b = $urandom_range(0, nblk - 1);
        if (r < 55) entry = dests[b] + 8 * $urandom_range(0, (sizes[b] - 1) / 8);
        else if (r < 70) entry = dests[b];
        else entry = pick_dest();
        budget = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : -1;
        quiet  = ($urandom_range(0, 7) == 0);

        emit(($urandom_range(0, 5) == 0) ? 16'($urandom) : KEY_VALUE,
             $urandom_range(0, 29) != 0);
        for (k = 0; k < RESERVED_WORDS_DEF; k++) begin
            emit(16'($urandom), 1'b0);
        end
        emit(entry[31:16], 1'b0);
        emit(entry[15:0], 1'b0);
        for (b = 0; b < nblk; b++) begin
            emit(16'(sizes[b]), 1'b0);
            emit(dests[b][31:16], 1'b0);
            emit(dests[b][15:0], 1'b0);
            for (g = 0; 8 * g < sizes[b]; g++) begin
                glen      = (sizes[b] - 8 * g > 8) ? 8 : sizes[b] - 8 * g;
                blank_grp = ($urandom_range(0, 4) == 0);
                for (k = 0; k < glen; k++) begin
                    emit((blank_grp || $urandom_range(0, 7) == 0) ? BLANK_WORD : 16'($urandom),
                         1'b0);
                end
                if (dests[b] + 32'(8 * g) == entry) break;
            end
        end
        if (budget != 0) begin
            emit(16'h0000, 1'b0);
            parked = 1'b1;
            if ($urandom_range(0, 3) == 0) emit(16'($urandom), 1'b0);
        end
        budget = -1;
    endtask

    task automatic run_images(input int target);
        while (n_items < target) begin
            if ((hold_count == 0 && n_items >= ITEMS / 3) ||
                (hold_count == 1 && n_items >= 2 * ITEMS / 3)) begin
                hold_count++;
            end
            send_image();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_regs();

        // image with no leading restart: good key, two groups, held entry group
        send_word(KEY_VALUE, 1'b0);
        send_word(16'h0000, 1'b0); send_word(16'hFFFF, 1'b0);
        send_word(16'h5A5A, 1'b0); send_word(16'hA5A5, 1'b0);
        send_word(16'h0001, 1'b0); send_word(16'h8000, 1'b0);
        send_word(16'h7FFF, 1'b0); send_word(16'hFFFE, 1'b0);
        send_word(16'h0008, 1'b0); send_word(16'h0010, 1'b0);
        send_word(16'd9, 1'b0);
        send_word(16'h0008, 1'b0); send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b0); send_word(16'hFFFF, 1'b0);
        send_word(16'h1234, 1'b0); send_word(16'h8000, 1'b0);
        send_word(16'h0001, 1'b0); send_word(16'hFFFF, 1'b0);
        send_word(16'h7FFF, 1'b0); send_word(16'hA5A5, 1'b0);
        send_word(16'hABCD, 1'b0);
        send_word(16'd1, 1'b0);
        send_word(16'h0008, 1'b0); send_word(16'h0010, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'h0000, 1'b0);
        parked = 1'b1;
        send_word(16'h1111, 1'b0);

        // bad key, entry never seen, blank group, wrap past the top of the address space
        send_word(16'hFFFF, 1'b1);
        repeat (RESERVED_WORDS_DEF) send_word(16'($urandom), 1'b0);
        send_word(16'h1234, 1'b0); send_word(16'h5678, 1'b0);
        send_word(16'd9, 1'b0);
        send_word(16'hFFFF, 1'b0); send_word(16'hFFF8, 1'b0);
        repeat (8) send_word(BLANK_WORD, 1'b0);
        send_word(16'h0042, 1'b0);
        send_word(16'h0000, 1'b0);
        parked = 1'b1;

        set_config($urandom, 16, 64);
        run_images(ITEMS / 6);
        set_config(32'h0000_0000, 1, 1);
        run_images(2 * ITEMS / 6);
        set_config(32'hFFF0_0000, 65536, 1048576);
        run_images(3 * ITEMS / 6);
        set_config($urandom, 8, 0);
        run_images(4 * ITEMS / 6);
        set_config(32'hFFFF_FFFF, 1, 16);
        run_images(5 * ITEMS / 6);
        set_config($urandom, $urandom_range(1, 64), $urandom_range(1, 512));
        run_images(ITEMS);

        quiet = 1'b0;
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN) @(posedge aclk);

        if (pending != 0) begin
            $error("%0d expected results never arrived", pending);
        end
        $display("covered %0d image words, %0d result transactions, %0d register settings",
                 n_items, result_count, n_settings);
        if (fail_count == 0 && read_fails == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/bibp_pkg.sv
hw/rtl/boot_image_block_parser.sv
hw/rtl/bibp_checker.sv
bench/bibp_result_checker.sv
bench/boot_image_block_parser_test.sv
